// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cfpb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpb_pkg
// types, register indexes and crc helper for the framed packet builder
// ----------------------------------------------------------------------------
package cfpb_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 1024;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int REG_IDX_W = 3;
  localparam int REG_DATA_W = 11;
  localparam int LEN_W = 11;

  localparam logic [REG_IDX_W-1:0] REG_SYNC_FIRST     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_SECOND    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VERSION_BYTE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MESSAGE_TYPE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYNC1,
    ST_SYNC2,
    ST_VER,
    ST_TYPE,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_DATA,
    ST_CRC_LO,
    ST_CRC_HI
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_of_frame;
    logic [15:0] crc_value;
  } out_beat_t;

  // crc-16/ccitt-false, one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/cfpb_obuf.sv =====
// ----------------------------------------------------------------------------
// cfpb_obuf
// output register stage for the frame byte channel
// ----------------------------------------------------------------------------
module cfpb_obuf import cfpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  input  out_beat_t   push_beat,
  output logic        push_ready,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  frame_byte,
  output logic        last_of_frame,
  output logic [15:0] crc_value
);

  out_beat_t beat;

  assign push_ready = !frame_valid || !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (push_ready) begin
      frame_valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      beat <= push_beat;
    end
  end

  assign frame_byte    = beat.frame_byte;
  assign last_of_frame = beat.last_of_frame;
  assign crc_value     = beat.crc_value;

endmodule

// ===== hw/rtl/crc16_framed_packet_builder_top.sv =====
// ----------------------------------------------------------------------------
// crc16_framed_packet_builder_top
// frames payload bytes with a sync/version/type/length header and crc trailer
// ----------------------------------------------------------------------------
// usage:
//   payload channel (payload_valid/payload_stall/payload_byte) takes one raw
//   byte per request. frame channel (frame_valid/frame_stall) gives one frame
//   byte per request with last_of_frame and crc_value.
//   the first byte of a frame brings out 7 bytes (6 header + payload), a
//   middle byte 1, the closing byte 3 (payload, crc low, crc high).
//   the sequencer emits one frame byte per cycle unless stalled, so middle
//   bytes go at one per cycle; first and last bytes hold the payload side
//   through header and trailer. the first frame byte passes the state and
//   output registers. crc takes one byte per cycle unless stalled, from version
//   through payload. the user must write registers via wr_en/wr_index/wr_data
//   while idle only; the block does not check it. writes to unused indexes
//   are dropped. reset clears the frame position, reloads crc with 0xffff and
//   register defaults. a frame-side stall holds the output register and backs
//   up into payload_stall once the sequencer has a byte waiting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc16_framed_packet_builder_top import cfpb_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data,
  input  logic                  payload_valid,
  output logic                  payload_stall,
  input  logic [7:0]            payload_byte,
  output logic                  frame_valid,
  input  logic                  frame_stall,
  output logic [7:0]            frame_byte,
  output logic                  last_of_frame,
  output logic [15:0]           crc_value
);

  localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD_BYTES);

  logic [7:0]       sync_first;
  logic [7:0]       sync_second;
  logic [7:0]       version_byte;
  logic [7:0]       message_type;
  logic [LEN_W-1:0] payload_length;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [LEN_W-1:0] payload_count;
  logic [15:0]      running_crc;
  logic [15:0]      running_crc_next;
  logic [7:0]       hold_byte;
  logic             hold_last;

  logic [15:0]      len_sat;
  logic [15:0]      len_use;
  logic [LEN_W-1:0] count_inc;
  logic             item_first;
  logic             item_last;
  logic             accept;

  out_beat_t        beat;
  logic             beat_valid;
  logic             push_ready;
  logic             take;
  logic             item_done;
  logic             crc_upd;
  seq_state_t       adv_state;

  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first     <= 8'd0;
      sync_second    <= 8'd0;
      version_byte   <= 8'd1;
      message_type   <= 8'd1;
      payload_length <= LEN_W'(64);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SYNC_FIRST:     sync_first     <= wr_data[7:0];
        REG_SYNC_SECOND:    sync_second    <= wr_data[7:0];
        REG_VERSION_BYTE:   version_byte   <= wr_data[7:0];
        REG_MESSAGE_TYPE:   message_type   <= wr_data[7:0];
        REG_PAYLOAD_LENGTH: payload_length <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length in use: clamp to max, at least two
  always_comb begin
    if ({6'd0, payload_length} > MaxLen) begin
      len_sat = MaxLen[15:0];
    end else begin
      len_sat = {5'd0, payload_length};
    end
    len_use = (len_sat < 16'd2) ? 16'd2 : len_sat;
  end

  assign count_inc  = payload_count + LEN_W'(1);
  assign item_first = (payload_count == '0);
  assign item_last  = ({5'd0, count_inc} >= len_use);

  // sequencer: one frame byte per state
  always_comb begin
    beat      = '0;
    adv_state = state;
    item_done = 1'b0;
    crc_upd   = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_SYNC1: begin
        beat.frame_byte = sync_first;
        adv_state = ST_SYNC2;
      end
      ST_SYNC2: begin
        beat.frame_byte = sync_second;
        adv_state = ST_VER;
      end
      ST_VER: begin
        beat.frame_byte = version_byte;
        crc_upd = 1'b1;
        adv_state = ST_TYPE;
      end
      ST_TYPE: begin
        beat.frame_byte = message_type;
        crc_upd = 1'b1;
        adv_state = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        beat.frame_byte = len_use[7:0];
        crc_upd = 1'b1;
        adv_state = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        beat.frame_byte = len_use[15:8];
        crc_upd = 1'b1;
        adv_state = ST_DATA;
      end
      ST_DATA: begin
        beat.frame_byte = hold_byte;
        crc_upd = 1'b1;
        if (hold_last) begin
          adv_state = ST_CRC_LO;
        end else begin
          item_done = 1'b1;
        end
      end
      ST_CRC_LO: begin
        beat.frame_byte = running_crc[7:0];
        adv_state = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        beat.frame_byte    = running_crc[15:8];
        beat.last_of_frame = 1'b1;
        beat.crc_value     = running_crc;
        item_done = 1'b1;
      end
      default: ;
    endcase

    beat_valid    = (state != ST_IDLE);
    take          = beat_valid && push_ready;
    payload_stall = !((state == ST_IDLE) || (take && item_done));
    accept        = payload_valid && !payload_stall;

    state_next = state;
    if (take) begin
      state_next = item_done ? ST_IDLE : adv_state;
    end
    if (accept) begin
      state_next = item_first ? ST_SYNC1 : ST_DATA;
    end

    running_crc_next = running_crc;
    if (take) begin
      if (state == ST_SYNC1 || state == ST_CRC_HI) begin
        running_crc_next = CRC_INIT;
      end else if (crc_upd) begin
        running_crc_next = crc_byte(running_crc, beat.frame_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      payload_count <= '0;
      running_crc   <= CRC_INIT;
    end else begin
      state       <= state_next;
      running_crc <= running_crc_next;
      if (accept) begin
        payload_count <= item_last ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= payload_byte;
      hold_last <= item_last;
    end
  end

  cfpb_obuf u_obuf (
    .clk           (clk),
    .rst           (rst),
    .push_valid    (beat_valid),
    .push_beat     (beat),
    .push_ready    (push_ready),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .frame_byte    (frame_byte),
    .last_of_frame (last_of_frame),
    .crc_value     (crc_value)
  );

  `ASSERT_IMPL(a_last_crc_hi, frame_valid && last_of_frame, crc_value[15:8] == frame_byte, "closing byte is not crc high byte")
  `ASSERT_IMPL(a_crc_zero, frame_valid && !last_of_frame, crc_value == 16'd0, "crc_value set on a non-closing byte")
  `ASSERT_NEXT(a_first_header, accept && item_first, state == ST_SYNC1, "first payload byte did not start a header")
  `ASSERT_IMPL(a_trailer_last, state == ST_CRC_LO || state == ST_CRC_HI, hold_last, "crc trailer without closing byte")

endmodule
